[src/vector4_fixed_alu_assert.svh]
// ----------------------------------------------------------------------------
// vector4_fixed_alu_assert.svh
// Assertion macros for the vector ALU checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR4_FIXED_ALU_ASSERT_SVH
`define VECTOR4_FIXED_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VFA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vfa assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VFA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vfa assertion failed");

`endif

[src/vfa_pkg.sv]
// ----------------------------------------------------------------------------
// vfa_pkg
// Types, constants and helpers shared by the vector ALU modules.
// ----------------------------------------------------------------------------
package vfa_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DW            = 32;  // component width
	localparam int SQ_IN_W       = 68;  // sum of four squares
	localparam int SQ_OUT_W      = 34;  // root bits
	localparam int DEN_W         = 36;  // signed divisor width
	localparam int SAT_W         = 70;  // working width ahead of saturation

	typedef enum logic [3:0] {
		FN_ADD    = 4'd0,
		FN_SUB    = 4'd1,
		FN_NEG    = 4'd2,
		FN_SCALE  = 4'd3,
		FN_DIV    = 4'd4,
		FN_DOT    = 4'd5,
		FN_LEN    = 4'd6,
		FN_SQLEN  = 4'd7,
		FN_NORM   = 4'd8,
		FN_DIST   = 4'd9,
		FN_SQDIST = 4'd10,
		FN_LERP   = 4'd11,
		FN_HOMOG  = 4'd12,
		FN_EQUAL  = 4'd13,
		FN_PASS   = 4'd14
	} func_t;

	typedef struct packed {
		logic [3:0]           func;
		logic signed [DW-1:0] a_x;
		logic signed [DW-1:0] a_y;
		logic signed [DW-1:0] a_z;
		logic signed [DW-1:0] a_w;
		logic signed [DW-1:0] b_x;
		logic signed [DW-1:0] b_y;
		logic signed [DW-1:0] b_z;
		logic signed [DW-1:0] b_w;
		logic signed [DW-1:0] scalar_in;
	} vfa_req_t;

	typedef struct packed {
		logic signed [DW-1:0] r_x;
		logic signed [DW-1:0] r_y;
		logic signed [DW-1:0] r_z;
		logic signed [DW-1:0] r_w;
		logic signed [DW-1:0] r_scalar;
		logic                 equal_flag;
		logic                 div_zero;
		logic                 a_is_point;
		logic                 a_is_vector;
		logic                 saturated;
	} vfa_rsp_t;

	// Work carried alongside the root and divide pipelines.
	typedef struct packed {
		logic [3:0]          func;
		logic [3:0][DW-1:0]  a;
		logic [DW-1:0]       s;
		logic [3:0][DW-1:0]  vec;
		logic [DW-1:0]       sc;
		logic                sat;
		logic                eq;
		logic                dz;
		logic                pt;
		logic                vc;
		logic                div_use;
	} vfa_side_t;

	typedef struct packed {
		logic [DW-1:0] val;
		logic          sat;
	} sat_res_t;

	localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32'sh7fffffff);
	localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(32'sh80000000);

	function automatic sat_res_t sat32(input logic signed [SAT_W-1:0] v);
		sat_res_t r;
		if (v > SAT_MAX) begin
			r.val = 32'h7fffffff;
			r.sat = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'h80000000;
			r.sat = 1'b1;
		end else begin
			r.val = v[DW-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

[src/vfa_isqrt.sv]
// ----------------------------------------------------------------------------
// vfa_isqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vfa_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [vfa_pkg::SQ_IN_W-1:0]   rad,
	output logic [vfa_pkg::SQ_OUT_W-1:0]  root
);
	import vfa_pkg::*;

	localparam int RW = SQ_IN_W + 2;

	logic [RW-1:0]       rem_q  [SQ_OUT_W+1];
	logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W+1];

	// trial = (root << (b+1)) + (1 << 2b): growth of root^2 when bit b is set
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= RW'(rad);
			root_q[0] <= '0;
			for (int j = 0; j < SQ_OUT_W; j++) begin
				if (rem_q[j] >= ((RW'(root_q[j]) << (SQ_OUT_W - j))
						+ (RW'(1) << (2 * (SQ_OUT_W - 1 - j))))) begin
					rem_q[j+1]  <= rem_q[j] - ((RW'(root_q[j]) << (SQ_OUT_W - j))
						+ (RW'(1) << (2 * (SQ_OUT_W - 1 - j))));
					root_q[j+1] <= root_q[j] | (SQ_OUT_W'(1) << (SQ_OUT_W - 1 - j));
				end else begin
					rem_q[j+1]  <= rem_q[j];
					root_q[j+1] <= root_q[j];
				end
			end
		end
	end

	assign root = root_q[SQ_OUT_W];

endmodule

[src/vfa_div_lane.sv]
// ----------------------------------------------------------------------------
// vfa_div_lane
// Pipelined restoring divider for one lane: (num << FRAC_BITS) / den,
// magnitude quotient with sign and overflow marks.
// ----------------------------------------------------------------------------
module vfa_div_lane #(
	parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [vfa_pkg::DW-1:0]     num,
	input  logic signed [vfa_pkg::DEN_W-1:0]  den,
	output logic [vfa_pkg::DW-1:0]            q,
	output logic                              ovf,
	output logic                              neg
);
	import vfa_pkg::*;

	localparam int QB = DW;
	localparam int RW = DEN_W + QB;

	logic signed [DW:0] num_x;
	logic [DW:0]        num_mag;
	logic [DEN_W-1:0]   den_mag;
	logic [RW-1:0]      num_sh;

	logic [RW-1:0]    rem_q [QB+1];
	logic [DEN_W-1:0] dm_q  [QB+1];
	logic [QB-1:0]    q_q   [QB+1];
	logic             ovf_q [QB+1];
	logic             neg_q [QB+1];

	assign num_x   = {num[DW-1], num};
	assign num_mag = num_x[DW] ? -num_x : num_x;
	assign den_mag = den[DEN_W-1] ? -den : den;
	assign num_sh  = RW'(num_mag) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num_sh;
			dm_q[0]  <= den_mag;
			q_q[0]   <= '0;
			ovf_q[0] <= num_sh >= (RW'(den_mag) << QB);
			neg_q[0] <= num[DW-1] ^ den[DEN_W-1];
			for (int j = 0; j < QB; j++) begin
				dm_q[j+1]  <= dm_q[j];
				ovf_q[j+1] <= ovf_q[j];
				neg_q[j+1] <= neg_q[j];
				if (rem_q[j] >= (RW'(dm_q[j]) << (QB - 1 - j))) begin
					rem_q[j+1] <= rem_q[j] - (RW'(dm_q[j]) << (QB - 1 - j));
					q_q[j+1]   <= q_q[j] | (QB'(1) << (QB - 1 - j));
				end else begin
					rem_q[j+1] <= rem_q[j];
					q_q[j+1]   <= q_q[j];
				end
			end
		end
	end

	assign q   = q_q[QB];
	assign ovf = ovf_q[QB];
	assign neg = neg_q[QB];

endmodule

[src/vector4_fixed_alu.sv]
// ----------------------------------------------------------------------------
// vector4_fixed_alu: four-lane Q(32-FRAC_BITS).FRAC_BITS vector ALU
// Stages: 3 front stages, 35 square-root stages, 33 divide stages and the
//   response register; the same for every operation.
// Throughput: one beat per cycle unless a response is held; the whole
//   pipeline advances on one enable.
// Reset: arst_n clears every valid bit; the pipeline is empty and ready.
// ----------------------------------------------------------------------------
module vector4_fixed_alu #(
	parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  vfa_pkg::vfa_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output vfa_pkg::vfa_rsp_t rsp
);
	import vfa_pkg::*;

	localparam logic [DW-1:0] ONE   = DW'(1) << FRAC_BITS;
	localparam int            SQ_LAT = SQ_OUT_W + 1;
	localparam int            DV_LAT = DW + 1;

	// Global advance: everything moves unless a response is held.
	logic en;
	assign en        = !rsp_valid | rsp_ready;
	assign req_ready = en;

	// valid line, one bit per stage
	logic v_s1, v_s2, v_s3;
	logic sqv_q [SQ_LAT];
	logic dvv_q [DV_LAT];
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < SQ_LAT; i++) sqv_q[i] <= 1'b0;
			for (int i = 0; i < DV_LAT; i++) dvv_q[i] <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1     <= req_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			sqv_q[0] <= v_s3;
			for (int i = 1; i < SQ_LAT; i++) sqv_q[i] <= sqv_q[i-1];
			dvv_q[0] <= sqv_q[SQ_LAT-1];
			for (int i = 1; i < DV_LAT; i++) dvv_q[i] <= dvv_q[i-1];
			rsp_valid_q <= dvv_q[DV_LAT-1];
		end
	end

	// ---------------- stage 1: request register ----------------
	vfa_req_t req_s1;
	always_ff @(posedge clk) begin
		if (en) req_s1 <= req;
	end

	// ---------------- stage 2: one multiplier per lane ----------------
	// Each lane picks its multiplier operands by op: a*s for scale, a*b for dot,
	// -(a-b)*t for lerp, squares of a or of a-b for the length family.
	logic signed [DW-1:0] a1 [4];
	logic signed [DW-1:0] b1 [4];
	logic signed [33:0]   d1 [4];
	logic signed [33:0]   opx [4];
	logic signed [33:0]   opy [4];
	logic signed [33:0]   lin1 [4];
	logic signed [DW-1:0] t1;

	logic signed [67:0]   prod_s2 [4];
	logic signed [33:0]   lin_s2  [4];
	logic [3:0]           func_s2;
	logic [3:0][DW-1:0]   a_s2;
	logic [DW-1:0]        s_s2;
	logic                 eq_s2, pt_s2, vc_s2, dz_s2;

	assign a1[0] = req_s1.a_x;
	assign a1[1] = req_s1.a_y;
	assign a1[2] = req_s1.a_z;
	assign a1[3] = req_s1.a_w;
	assign b1[0] = req_s1.b_x;
	assign b1[1] = req_s1.b_y;
	assign b1[2] = req_s1.b_z;
	assign b1[3] = req_s1.b_w;

	// lerp parameter clamped to 0..one
	always_comb begin
		if (req_s1.scalar_in[DW-1])
			t1 = '0;
		else if (req_s1.scalar_in > $signed(ONE))
			t1 = ONE;
		else
			t1 = req_s1.scalar_in;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			d1[i] = 34'(a1[i]) - 34'(b1[i]);
			case (func_t'(req_s1.func))
				FN_SCALE: begin
					opx[i] = 34'(a1[i]);
					opy[i] = 34'(req_s1.scalar_in);
				end
				FN_DOT: begin
					opx[i] = 34'(a1[i]);
					opy[i] = 34'(b1[i]);
				end
				FN_LERP: begin
					opx[i] = -d1[i];
					opy[i] = 34'(t1);
				end
				FN_LEN, FN_SQLEN, FN_NORM: begin
					opx[i] = 34'(a1[i]);
					opy[i] = 34'(a1[i]);
				end
				FN_DIST, FN_SQDIST: begin
					opx[i] = d1[i];
					opy[i] = d1[i];
				end
				default: begin
					opx[i] = '0;
					opy[i] = '0;
				end
			endcase
			case (func_t'(req_s1.func))
				FN_ADD:  lin1[i] = 34'(a1[i]) + 34'(b1[i]);
				FN_SUB:  lin1[i] = d1[i];
				FN_NEG:  lin1[i] = -34'(a1[i]);
				default: lin1[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= opx[i] * opy[i];
				lin_s2[i]  <= lin1[i];
				a_s2[i]    <= a1[i];
			end
			func_s2 <= req_s1.func;
			s_s2    <= req_s1.scalar_in;
			eq_s2   <= (a1[0] == b1[0]) && (a1[1] == b1[1])
				&& (a1[2] == b1[2]) && (a1[3] == b1[3]);
			pt_s2   <= req_s1.a_w == $signed(ONE);
			vc_s2   <= req_s1.a_w == '0;
			dz_s2   <= (func_t'(req_s1.func) == FN_DIV) && (req_s1.scalar_in == '0);
		end
	end

	// ---------------- stage 3: shifts, sums, saturation ----------------
	// Dot, squared length and squared distance all reduce to the floor of
	// the summed products shifted down by FRAC_BITS.
	logic signed [SAT_W-1:0] psum;
	logic signed [SAT_W-1:0] lane_v [4];
	sat_res_t                lane_r [4];
	sat_res_t                sc_r;
	vfa_side_t               side_c;

	vfa_side_t               side_s3;
	logic [SQ_IN_W-1:0]      sumsq_s3;

	always_comb begin
		psum = '0;
		for (int i = 0; i < 4; i++) psum = psum + SAT_W'(prod_s2[i]);
		sc_r = sat32(psum >>> FRAC_BITS);

		side_c         = '0;
		side_c.func    = func_s2;
		side_c.a       = a_s2;
		side_c.s       = s_s2;
		side_c.eq      = eq_s2;
		side_c.pt      = pt_s2;
		side_c.vc      = vc_s2;
		side_c.dz      = dz_s2;

		for (int i = 0; i < 4; i++) begin
			case (func_t'(func_s2))
				FN_SCALE: lane_v[i] = SAT_W'(prod_s2[i] >>> FRAC_BITS);
				FN_LERP:  lane_v[i] = SAT_W'($signed(a_s2[i]))
					+ SAT_W'(prod_s2[i] >>> FRAC_BITS);
				default:  lane_v[i] = SAT_W'(lin_s2[i]);
			endcase
			lane_r[i] = sat32(lane_v[i]);
			case (func_t'(func_s2))
				FN_ADD, FN_SUB, FN_NEG, FN_SCALE, FN_LERP: begin
					side_c.vec[i] = lane_r[i].val;
					side_c.sat    = side_c.sat | lane_r[i].sat;
				end
				FN_DIV, FN_DOT, FN_LEN, FN_SQLEN, FN_NORM, FN_DIST, FN_SQDIST,
				FN_EQUAL:
					side_c.vec[i] = '0;
				default:
					side_c.vec[i] = a_s2[i];  // passthrough, homogenize with w zero
			endcase
		end

		case (func_t'(func_s2))
			FN_DOT, FN_SQLEN, FN_SQDIST: begin
				side_c.sc  = sc_r.val;
				side_c.sat = side_c.sat | sc_r.sat;
			end
			default: side_c.sc = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3  <= side_c;
			sumsq_s3 <= psum[SQ_IN_W-1:0];
		end
	end

	// ---------------- square root ----------------
	logic [SQ_OUT_W-1:0] root;
	vfa_side_t           sd_q [SQ_LAT];

	vfa_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sumsq_s3),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= side_s3;
			for (int i = 1; i < SQ_LAT; i++) sd_q[i] <= sd_q[i-1];
		end
	end

	// Root is in: finish length and distance, pick the divisor.
	vfa_side_t               side_m;
	sat_res_t                root_r;
	logic signed [DEN_W-1:0] den;

	always_comb begin
		side_m = sd_q[SQ_LAT-1];
		root_r = sat32(SAT_W'(root));
		den    = '0;
		case (func_t'(side_m.func))
			FN_LEN, FN_DIST: begin
				side_m.sc  = root_r.val;
				side_m.sat = side_m.sat | root_r.sat;
			end
			FN_DIV: begin
				den            = DEN_W'($signed(side_m.s));
				side_m.div_use = side_m.s != '0;
			end
			FN_NORM: begin
				den            = DEN_W'(root);
				side_m.div_use = root != '0;
			end
			FN_HOMOG: begin
				den            = DEN_W'($signed(side_m.a[3]));
				side_m.div_use = side_m.a[3] != '0;
			end
			default: ;
		endcase
	end

	// ---------------- divide lanes ----------------
	logic [DW-1:0] dq   [4];
	logic          dovf [4];
	logic          dneg [4];
	vfa_side_t     dd_q [DV_LAT];

	for (genvar g = 0; g < 4; g++) begin : g_lane
		vfa_div_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk (clk),
			.en  (en),
			.num ($signed(side_m.a[g])),
			.den (den),
			.q   (dq[g]),
			.ovf (dovf[g]),
			.neg (dneg[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_q[0] <= side_m;
			for (int i = 1; i < DV_LAT; i++) dd_q[i] <= dd_q[i-1];
		end
	end

	// ---------------- merge and response register ----------------
	// Divide, normalize and homogenize take the lane quotients when the divisor
	// is nonzero; homogenize then forces w to one. Flags from all stages fold into the beat here.
	vfa_side_t               dside;
	logic signed [SAT_W-1:0] dmag [4];
	logic signed [SAT_W-1:0] dval [4];
	sat_res_t                dres [4];
	logic [3:0][DW-1:0]      vec_f;
	logic                    sat_f;
	vfa_rsp_t                rsp_c;
	vfa_rsp_t                rsp_q;

	always_comb begin
		dside = dd_q[DV_LAT-1];
		vec_f = dside.vec;
		sat_f = dside.sat;
		for (int i = 0; i < 4; i++) begin
			dmag[i] = dovf[i] ? (SAT_W'(1) << 40) : SAT_W'(dq[i]);
			dval[i] = dneg[i] ? -dmag[i] : dmag[i];
			dres[i] = sat32(dval[i]);
			if (dside.div_use) begin
				if ((i == 3) && (func_t'(dside.func) == FN_HOMOG)) begin
					vec_f[i] = ONE;
				end else begin
					vec_f[i] = dres[i].val;
					sat_f    = sat_f | dres[i].sat;
				end
			end
		end
		rsp_c.r_x         = vec_f[0];
		rsp_c.r_y         = vec_f[1];
		rsp_c.r_z         = vec_f[2];
		rsp_c.r_w         = vec_f[3];
		rsp_c.r_scalar    = dside.sc;
		rsp_c.equal_flag  = dside.eq;
		rsp_c.div_zero    = dside.dz;
		rsp_c.a_is_point  = dside.pt;
		rsp_c.a_is_vector = dside.vc;
		rsp_c.saturated   = sat_f;
	end

	always_ff @(posedge clk) begin
		if (en) rsp_q <= rsp_c;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

[src/vfa_checker.sv]
// ----------------------------------------------------------------------------
// vfa_checker
// Port-level checks on the vector ALU handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector4_fixed_alu_assert.svh"

module vfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input vfa_pkg::vfa_rsp_t rsp
);
	// empty output stage always frees the pipe
	`VFA_ASSERT_IMP(a_idle_ready, !rsp_valid, req_ready)
	// a beat taken at the output lets a request in the same cycle
	`VFA_ASSERT_IMP(a_take_ready, rsp_valid && rsp_ready, req_ready)
	`VFA_ASSERT_NXT(a_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
	`VFA_ASSERT_NXT(a_hold_data, rsp_valid && !rsp_ready, $stable(rsp))

endmodule

bind vector4_fixed_alu vfa_checker u_vfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
